@@ design/owt_pkg.sv @@
`timescale 1ns / 1ps

package owt_pkg;

  localparam int OWT_COUNTER_BITS = 20;
  localparam int OWT_LIMIT_W      = 20;
  localparam int OWT_CFG_IDX_W    = 4;
  localparam int OWT_CFG_DATA_W   = 20;

  localparam logic [7:0] OWT_CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] OWT_CMD_CONVERT  = 8'h44;
  localparam logic [7:0] OWT_CMD_READ_PAD = 8'hBE;

  localparam logic [7:0] OWT_CMD_TABLE [4] = '{
    OWT_CMD_SKIP_ROM, OWT_CMD_CONVERT, OWT_CMD_SKIP_ROM, OWT_CMD_READ_PAD
  };

  // Register reset values
  localparam logic [15:0] OWT_RST_RESET_LOW    = 16'd480;
  localparam logic [15:0] OWT_RST_PRES_WAIT    = 16'd70;
  localparam logic [15:0] OWT_RST_RESET_TAIL   = 16'd410;
  localparam logic [15:0] OWT_RST_WR_ZERO_LOW  = 16'd60;
  localparam logic [7:0]  OWT_RST_SHORT_LOW    = 8'd2;
  localparam logic [7:0]  OWT_RST_READ_SAMPLE  = 8'd12;
  localparam logic [15:0] OWT_RST_SLOT_REC     = 16'd50;
  localparam logic [19:0] OWT_RST_CONV_WAIT    = 20'd0;

  typedef enum logic [OWT_CFG_IDX_W-1:0] {
    OWT_REG_RESET_LOW   = 4'd0,
    OWT_REG_PRES_WAIT   = 4'd1,
    OWT_REG_RESET_TAIL  = 4'd2,
    OWT_REG_WR_ZERO_LOW = 4'd3,
    OWT_REG_SHORT_LOW   = 4'd4,
    OWT_REG_READ_SAMPLE = 4'd5,
    OWT_REG_SLOT_REC    = 4'd6,
    OWT_REG_CONV_WAIT   = 4'd7
  } owt_reg_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [15:0] reset_tail_ticks;
    logic [15:0] write_zero_low_ticks;
    logic [7:0]  short_low_ticks;
    logic [7:0]  read_sample_ticks;
    logic [15:0] slot_recovery_ticks;
    logic [19:0] conversion_wait_ticks;
  } owt_cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_ok;
    logic signed [15:0] temp_raw;
    logic signed [11:0] temp_degrees;
  } owt_result_t;

  typedef enum logic [9:0] {
    OWT_PH_IDLE     = 10'b00_0000_0001,
    OWT_PH_RST_LOW  = 10'b00_0000_0010,
    OWT_PH_RST_WAIT = 10'b00_0000_0100,
    OWT_PH_RST_TAIL = 10'b00_0000_1000,
    OWT_PH_WR_LOW   = 10'b00_0001_0000,
    OWT_PH_WR_REC   = 10'b00_0010_0000,
    OWT_PH_RD_LOW   = 10'b00_0100_0000,
    OWT_PH_RD_WAIT  = 10'b00_1000_0000,
    OWT_PH_RD_REC   = 10'b01_0000_0000,
    OWT_PH_CONV     = 10'b10_0000_0000
  } owt_phase_t;

  // Bit of the command byte sent at the given byte step, least significant first.
  function automatic logic owt_cmd_bit(input logic [2:0] step, input logic [2:0] bit_idx);
    logic [7:0] cmd;
    cmd = OWT_CMD_TABLE[step[1:0]];
    return cmd[bit_idx];
  endfunction

endpackage

@@ design/owt_cfg_regs.sv @@
`timescale 1ns / 1ps

module owt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [owt_pkg::OWT_CFG_IDX_W-1:0]  cfg_index,
  input  logic [owt_pkg::OWT_CFG_DATA_W-1:0] cfg_data,
  output owt_pkg::owt_cfg_t                  cfg
);
  import owt_pkg::*;

  owt_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        OWT_REG_RESET_LOW:   cfg_nxt.reset_low_ticks       = cfg_data[15:0];
        OWT_REG_PRES_WAIT:   cfg_nxt.presence_wait_ticks   = cfg_data[15:0];
        OWT_REG_RESET_TAIL:  cfg_nxt.reset_tail_ticks      = cfg_data[15:0];
        OWT_REG_WR_ZERO_LOW: cfg_nxt.write_zero_low_ticks  = cfg_data[15:0];
        OWT_REG_SHORT_LOW:   cfg_nxt.short_low_ticks       = cfg_data[7:0];
        OWT_REG_READ_SAMPLE: cfg_nxt.read_sample_ticks     = cfg_data[7:0];
        OWT_REG_SLOT_REC:    cfg_nxt.slot_recovery_ticks   = cfg_data[15:0];
        OWT_REG_CONV_WAIT:   cfg_nxt.conversion_wait_ticks = cfg_data[19:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= OWT_RST_RESET_LOW;
      cfg_r.presence_wait_ticks   <= OWT_RST_PRES_WAIT;
      cfg_r.reset_tail_ticks      <= OWT_RST_RESET_TAIL;
      cfg_r.write_zero_low_ticks  <= OWT_RST_WR_ZERO_LOW;
      cfg_r.short_low_ticks       <= OWT_RST_SHORT_LOW;
      cfg_r.read_sample_ticks     <= OWT_RST_READ_SAMPLE;
      cfg_r.slot_recovery_ticks   <= OWT_RST_SLOT_REC;
      cfg_r.conversion_wait_ticks <= OWT_RST_CONV_WAIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/owt_temp_conv.sv @@
`timescale 1ns / 1ps

module owt_temp_conv (
  input  logic signed [15:0] temp_raw,
  output logic signed [11:0] temp_degrees
);
  import owt_pkg::*;

  logic [16:0] mag_full;
  logic [12:0] mag;
  logic [11:0] neg_deg;

  // Negative readings truncate toward zero: negate, shift, negate back.
  assign mag_full = 17'h10000 - {1'b0, temp_raw};
  assign mag      = mag_full[16:4];
  assign neg_deg  = 12'd0 - mag[11:0];

  assign temp_degrees = temp_raw[15] ? signed'(neg_deg) : signed'(temp_raw[15:4]);

endmodule

@@ design/owt_seq_core.sv @@
`timescale 1ns / 1ps

module owt_seq_core #(
  parameter int COUNTER_BITS = owt_pkg::OWT_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 start_req,
  input  logic                 line_level,
  input  owt_pkg::owt_cfg_t    cfg,
  output owt_pkg::owt_result_t result
);
  import owt_pkg::*;

  localparam int CMP_W = (COUNTER_BITS >= OWT_LIMIT_W) ? COUNTER_BITS + 1 : OWT_LIMIT_W + 1;

  owt_phase_t              phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [2:0]              bit_index_r, bit_index_nxt;
  logic [2:0]              byte_step_r, byte_step_nxt;
  logic [7:0]              shift_byte_r, shift_byte_nxt;
  logic [15:0]             raw_reading_r, raw_reading_nxt;
  logic                    presence_r, presence_nxt;

  logic [OWT_LIMIT_W-1:0]  limit;
  logic [CMP_W-1:0]        cnt_inc;
  logic                    t_done;
  logic [COUNTER_BITS-1:0] tick_timer;
  logic [2:0]              byte_step_inc;
  logic                    drive, busy, done;
  logic signed [11:0]      degrees;

  always_comb begin
    unique case (phase_r)
      OWT_PH_RST_LOW:  limit = OWT_LIMIT_W'(cfg.reset_low_ticks);
      OWT_PH_RST_WAIT: limit = OWT_LIMIT_W'(cfg.presence_wait_ticks);
      OWT_PH_RST_TAIL: limit = OWT_LIMIT_W'(cfg.reset_tail_ticks);
      OWT_PH_WR_LOW:   limit = owt_cmd_bit(byte_step_r, bit_index_r)
                               ? OWT_LIMIT_W'(cfg.short_low_ticks)
                               : OWT_LIMIT_W'(cfg.write_zero_low_ticks);
      OWT_PH_WR_REC,
      OWT_PH_RD_REC:   limit = OWT_LIMIT_W'(cfg.slot_recovery_ticks);
      OWT_PH_RD_LOW:   limit = OWT_LIMIT_W'(cfg.short_low_ticks);
      OWT_PH_RD_WAIT:  limit = OWT_LIMIT_W'(cfg.read_sample_ticks);
      OWT_PH_CONV:     limit = cfg.conversion_wait_ticks;
      default:         limit = '0;
    endcase
  end

  // The phase ends when the counter is all ones, so no phase runs past its full range.
  assign cnt_inc    = CMP_W'(tick_count_r) + CMP_W'(1);
  assign t_done     = (cnt_inc >= CMP_W'(limit)) || (&tick_count_r);
  assign tick_timer = t_done ? '0 : tick_count_r + COUNTER_BITS'(1);
  assign byte_step_inc = byte_step_r + 3'd1;

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_index_nxt   = bit_index_r;
    byte_step_nxt   = byte_step_r;
    shift_byte_nxt  = shift_byte_r;
    raw_reading_nxt = raw_reading_r;
    presence_nxt    = presence_r;
    drive           = 1'b0;
    busy            = 1'b1;
    done            = 1'b0;
    unique case (phase_r)
      OWT_PH_IDLE: begin
        busy = start_req;
        if (start_req) begin
          presence_nxt   = 1'b1;
          byte_step_nxt  = '0;
          bit_index_nxt  = '0;
          shift_byte_nxt = '0;
          tick_count_nxt = '0;
          phase_nxt      = OWT_PH_RST_LOW;
        end
      end
      OWT_PH_RST_LOW: begin
        drive          = 1'b1;
        tick_count_nxt = tick_timer;
        if (t_done) phase_nxt = OWT_PH_RST_WAIT;
      end
      OWT_PH_RST_WAIT: begin
        tick_count_nxt = tick_timer;
        if (t_done) begin
          if (line_level) presence_nxt = 1'b0;
          phase_nxt = OWT_PH_RST_TAIL;
        end
      end
      OWT_PH_RST_TAIL: begin
        tick_count_nxt = tick_timer;
        if (t_done) phase_nxt = byte_step_r[2] ? OWT_PH_RD_LOW : OWT_PH_WR_LOW;
      end
      OWT_PH_WR_LOW: begin
        drive          = 1'b1;
        tick_count_nxt = tick_timer;
        if (t_done) phase_nxt = OWT_PH_WR_REC;
      end
      OWT_PH_RD_LOW: begin
        drive          = 1'b1;
        tick_count_nxt = tick_timer;
        if (t_done) phase_nxt = OWT_PH_RD_WAIT;
      end
      OWT_PH_RD_WAIT: begin
        tick_count_nxt = tick_timer;
        if (t_done) begin
          shift_byte_nxt = ((bit_index_r == 3'd0) ? 8'd0 : shift_byte_r)
                           | (8'(line_level) << bit_index_r);
          phase_nxt = OWT_PH_RD_REC;
        end
      end
      OWT_PH_WR_REC,
      OWT_PH_RD_REC: begin
        tick_count_nxt = tick_timer;
        if (t_done) begin
          if (bit_index_r != 3'd7) begin
            bit_index_nxt = bit_index_r + 3'd1;
            phase_nxt     = byte_step_r[2] ? OWT_PH_RD_LOW : OWT_PH_WR_LOW;
          end else begin
            bit_index_nxt = '0;
            byte_step_nxt = byte_step_inc;
            unique case (byte_step_r)
              3'd0, 3'd2, 3'd3: begin
                phase_nxt = byte_step_inc[2] ? OWT_PH_RD_LOW : OWT_PH_WR_LOW;
              end
              3'd1: begin
                // After the convert command, wait or go straight to the second reset.
                phase_nxt = (cfg.conversion_wait_ticks != '0) ? OWT_PH_CONV
                                                              : OWT_PH_RST_LOW;
              end
              3'd4: begin
                raw_reading_nxt = {raw_reading_r[15:8], shift_byte_r};
                phase_nxt       = byte_step_inc[2] ? OWT_PH_RD_LOW : OWT_PH_WR_LOW;
              end
              default: begin
                raw_reading_nxt = {shift_byte_r, raw_reading_r[7:0]};
                phase_nxt       = OWT_PH_IDLE;
                byte_step_nxt   = '0;
                done            = 1'b1;
              end
            endcase
          end
        end
      end
      OWT_PH_CONV: begin
        tick_count_nxt = tick_timer;
        if (t_done) phase_nxt = OWT_PH_RST_LOW;
      end
      default: begin
        phase_nxt = OWT_PH_IDLE;
        busy      = 1'b0;
      end
    endcase
  end

  owt_temp_conv u_conv (
    .temp_raw     (signed'(raw_reading_nxt)),
    .temp_degrees (degrees)
  );

  assign result.drive_low    = drive;
  assign result.busy_res     = busy;
  assign result.done_res     = done;
  assign result.presence_ok  = presence_nxt;
  assign result.temp_raw     = signed'(raw_reading_nxt);
  assign result.temp_degrees = degrees;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= OWT_PH_IDLE;
      tick_count_r  <= '0;
      bit_index_r   <= '0;
      byte_step_r   <= '0;
      shift_byte_r  <= '0;
      raw_reading_r <= '0;
      presence_r    <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      bit_index_r   <= bit_index_nxt;
      byte_step_r   <= byte_step_nxt;
      shift_byte_r  <= shift_byte_nxt;
      raw_reading_r <= raw_reading_nxt;
      presence_r    <= presence_nxt;
    end
  end

endmodule

@@ design/onewire_temp_read_sequencer.sv @@
`timescale 1ns / 1ps

// One-wire bus master that reads a temperature sensor, one timebase tick per
// input transaction. Each transaction carries the start request and the sampled
// line level, and gives exactly one result transaction: the line drive for that
// tick, busy and done flags, the presence flag, the raw reading and whole
// degrees. A tick is accepted every clock cycle while in_stall is low; the
// sequencer state advances once per tick through a single pass of logic
// between the input register and the result register. The held tick moves
// into the result register once that register is free or draining, and
// throughput is one tick per cycle while the result side is not stalled.
// Slot timings come from the configuration registers, which the user must
// write only while no sequence runs; the block itself does not enforce this.
module onewire_temp_read_sequencer #(
  parameter int COUNTER_BITS = owt_pkg::OWT_COUNTER_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_start_req,
  input  logic                               in_line_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_drive_low,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_presence_ok,
  output logic signed [15:0]                 out_temp_raw,
  output logic signed [11:0]                 out_temp_degrees,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [owt_pkg::OWT_CFG_IDX_W-1:0]  cfg_index,
  input  logic [owt_pkg::OWT_CFG_DATA_W-1:0] cfg_data
);
  import owt_pkg::*;

  owt_cfg_t    cfg;
  owt_result_t result;
  owt_result_t out_r;

  logic in_valid_r, in_valid_nxt;
  logic in_start_r, in_line_r;
  logic out_valid_r, out_valid_nxt;
  logic in_take, advance;

  // The held tick moves on whenever the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  owt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owt_seq_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .start_req  (in_start_r),
    .line_level (in_line_r),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_start_r <= in_start_req;
      in_line_r  <= in_line_level;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_low    = out_r.drive_low;
  assign out_busy_res     = out_r.busy_res;
  assign out_done_res     = out_r.done_res;
  assign out_presence_ok  = out_r.presence_ok;
  assign out_temp_raw     = out_r.temp_raw;
  assign out_temp_degrees = out_r.temp_degrees;

  // The line is only ever pulled low while a sequence runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("line driven low outside a sequence");

  // The finishing tick belongs to the sequence and releases the line.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res && !out_drive_low)
    else $error("done tick not busy or line still driven");

  // An accepted tick is always held in the input register next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_valid_r)
    else $error("accepted tick lost");

endmodule
